FILE: rtl/rqfbo_pkg.sv
// ----------------------------------------------------------------------------
// Ring queue package
// Request, status and register codes, channel payload types and the
// command bundle between the queue controller and its datapath.
// ----------------------------------------------------------------------------
package rqfbo_pkg;

    localparam int ITEM_W = 32;
    localparam int CNT_W  = 5;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [REQ_W-1:0] REQ_BACK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FRONT     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OVERWRITE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RECEIVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESET     = 3'd4;

    localparam logic [STS_W-1:0] ST_PASS  = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTING_ONLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ITEM_W-1:0] item_in;
    } t_in_item;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [ITEM_W-1:0] item_out;
        logic [CNT_W-1:0]  fill_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_ctl_cmd;

endpackage

FILE: rtl/rqfbo_ctrl.sv
// ----------------------------------------------------------------------------
// Ring queue controller
// Sequences one transaction at a time: capture, execute, deliver to the
// output register once it is free.
// ----------------------------------------------------------------------------
module rqfbo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rqfbo_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.emit = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_cmd.exec)
        else $error("accepted transaction not executed");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.emit}))
        else $error("conflicting datapath commands");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_out_valid)
        else $error("result loaded without valid");

endmodule

FILE: rtl/rqfbo_dp.sv
// ----------------------------------------------------------------------------
// Ring queue datapath
// Configuration registers, slot memory, indices, message count and the
// output register.
// ----------------------------------------------------------------------------
module rqfbo_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rqfbo_pkg::t_ctl_cmd                  i_cmd,
    input  rqfbo_pkg::t_in_item                  i_in_item,
    input  logic                                 i_cfg_we,
    input  logic [rqfbo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rqfbo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output rqfbo_pkg::t_out_item                 o_out_item
);

    localparam int CNT_W   = rqfbo_pkg::CNT_W;
    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_INT = (QUEUE_DEPTH > CNT_MAX) ? CNT_MAX : QUEUE_DEPTH;
    localparam logic [CNT_W-1:0] LEN_CAP   = CNT_W'(CAP_INT);
    localparam logic [IDX_W-1:0] RI_RESET  = IDX_W'(QUEUE_DEPTH - 1);

    logic [CNT_W-1:0] r_queue_length;
    logic             r_counting_only;
    logic [CNT_W-1:0] r_initial_count;

    logic [rqfbo_pkg::ITEM_W-1:0] r_slot_store [QUEUE_DEPTH];
    logic [IDX_W-1:0]             r_write_index;
    logic [IDX_W-1:0]             r_read_index;
    logic [CNT_W-1:0]             r_message_count;

    rqfbo_pkg::t_in_item           r_req;
    logic [rqfbo_pkg::ITEM_W-1:0]  r_rd_data;
    logic [rqfbo_pkg::STS_W-1:0]   r_res_status;
    logic                          r_res_take;
    rqfbo_pkg::t_out_item          r_out;

    logic [IDX_W-1:0]             n_write_index;
    logic [IDX_W-1:0]             n_read_index;
    logic [CNT_W-1:0]             n_message_count;
    logic [rqfbo_pkg::STS_W-1:0]  n_status;
    logic                         n_take;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_addr;

    logic [CNT_W-1:0] len;
    logic [CMP_W-1:0] len_x;
    logic [IDX_W-1:0] wi_inc;
    logic [IDX_W-1:0] ri_inc;
    logic [IDX_W-1:0] ri_dec;
    logic [IDX_W-1:0] len_m1;
    logic [CNT_W-1:0] init_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_length  <= CNT_W'(16);
            r_counting_only <= 1'b0;
            r_initial_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rqfbo_pkg::CFG_QUEUE_LENGTH:  r_queue_length  <= i_cfg_data;
                rqfbo_pkg::CFG_COUNTING_ONLY: r_counting_only <= i_cfg_data[0];
                rqfbo_pkg::CFG_INITIAL_COUNT: r_initial_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_queue_length == '0) begin
            len = CNT_W'(1);
        end else if (r_queue_length > LEN_CAP) begin
            len = LEN_CAP;
        end else begin
            len = r_queue_length;
        end
        len_x    = CMP_W'(len);
        len_m1   = IDX_W'(len_x - CMP_W'(1));
        wi_inc   = ((CMP_W'(r_write_index) + CMP_W'(1)) >= len_x) ?
                   '0 : r_write_index + IDX_W'(1);
        ri_inc   = ((CMP_W'(r_read_index) + CMP_W'(1)) >= len_x) ?
                   '0 : r_read_index + IDX_W'(1);
        ri_dec   = (r_read_index == '0) ? len_m1 : r_read_index - IDX_W'(1);
        init_sat = (r_initial_count > len) ? len : r_initial_count;
    end

    always_comb begin
        n_write_index   = r_write_index;
        n_read_index    = r_read_index;
        n_message_count = r_message_count;
        n_status        = rqfbo_pkg::ST_PASS;
        n_take          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = r_write_index;
        unique case (r_req.req_type) inside
            rqfbo_pkg::REQ_BACK, rqfbo_pkg::REQ_FRONT: begin
                if (r_message_count >= len) begin
                    n_status = rqfbo_pkg::ST_FULL;
                end else begin
                    if (!r_counting_only) begin
                        mem_we = 1'b1;
                        if (r_req.req_type == rqfbo_pkg::REQ_BACK) begin
                            n_write_index = wi_inc;
                        end else begin
                            mem_addr     = r_read_index;
                            n_read_index = ri_dec;
                        end
                    end
                    n_message_count = r_message_count + CNT_W'(1);
                end
            end
            rqfbo_pkg::REQ_OVERWRITE: begin
                if (!r_counting_only) begin
                    mem_we       = 1'b1;
                    mem_addr     = r_read_index;
                    n_read_index = ri_dec;
                end
                if (r_message_count == '0) begin
                    n_message_count = CNT_W'(1);
                end
            end
            rqfbo_pkg::REQ_RECEIVE: begin
                if (r_message_count == '0) begin
                    n_status = rqfbo_pkg::ST_EMPTY;
                end else begin
                    if (!r_counting_only) begin
                        n_read_index = ri_inc;
                        n_take       = 1'b1;
                    end
                    n_message_count = r_message_count - CNT_W'(1);
                end
            end
            rqfbo_pkg::REQ_RESET: begin
                n_write_index   = '0;
                n_read_index    = len_m1;
                n_message_count = r_counting_only ? init_sat : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index   <= '0;
            r_read_index    <= RI_RESET;
            r_message_count <= '0;
        end else if (i_cmd.exec) begin
            r_write_index   <= n_write_index;
            r_read_index    <= n_read_index;
            r_message_count <= n_message_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_slot_store[mem_addr] <= r_req.item_in;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_slot_store[ri_inc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_res_status <= n_status;
            r_res_take   <= n_take;
        end
        if (i_cmd.emit) begin
            r_out.status     <= r_res_status;
            r_out.item_out   <= r_res_take ? r_rd_data : '0;
            r_out.fill_count <= r_message_count;
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: rtl/ring_queue_front_back_overwrite_top.sv
// ----------------------------------------------------------------------------
// Ring queue with front, back and overwrite sends
// Circular message queue engine: send back, send front, overwrite,
// receive and queue reset, with an optional count-only mode.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_ready) as a
//   request code and an item. Each transaction gives exactly one result on
//   the output channel (o_out_valid / i_out_ready): status, received item
//   and the message count after the request.
//   An accepted request is captured, executed, then delivered to the output
//   register once it is free, and only then is a new request taken; the
//   controller runs these steps in turn; the slot memory read is registered.
//   The input side accepts a new request while a result still waits in the
//   output register; when the receiver stalls, the following request holds
//   in the deliver step until the output register is taken.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
//   once. Issue them only while the queue is idle; the block does not check.
//   Reset: empty queue, write index 0, read index at the last slot,
//   length 16, data mode, initial count 0. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module ring_queue_front_back_overwrite_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rqfbo_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rqfbo_pkg::t_out_item                 o_out_item,
    input  logic                                 i_cfg_we,
    input  logic [rqfbo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rqfbo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rqfbo_pkg::t_ctl_cmd cmd;

    rqfbo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    rqfbo_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

FILE: bench/ring_queue_front_back_overwrite_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring queue testbench
// Drives requests through the queue engine under random valid/ready
// idling, predicts every result with a local copy of the queue state and
// compares status, received item and fill count field by field. A short
// directed table covers the corner cases, then random phases step through
// queue lengths, counting mode and initial counts.
// ----------------------------------------------------------------------------
module ring_queue_front_back_overwrite_top_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 108;
    localparam int FIXED_PH    = 9;
    localparam int DIR_N       = 28;
    localparam int MAX_PRINTS  = 50;

    localparam logic [rqfbo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [rqfbo_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [rqfbo_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [rqfbo_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

    localparam logic [rqfbo_pkg::CFG_DATA_W-1:0] PH_LEN [FIXED_PH] =
        '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5, 5'd8, 5'd16, 5'd3};
    localparam logic PH_CNT [FIXED_PH] =
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam logic [rqfbo_pkg::CFG_DATA_W-1:0] PH_INIT [FIXED_PH] =
        '{5'd0, 5'd0, 5'd0, 5'd0, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2};

    typedef struct packed {
        logic                             is_cfg;
        logic [rqfbo_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [rqfbo_pkg::CFG_DATA_W-1:0] cfg_val;
        rqfbo_pkg::t_in_item              req;
        logic                             typed;
        rqfbo_pkg::t_out_item             want;
    } t_plan_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    rqfbo_pkg::t_in_item              i_in_item;
    logic                             o_out_valid;
    logic                             i_out_ready;
    rqfbo_pkg::t_out_item             o_out_item;
    logic                             i_cfg_we;
    logic [rqfbo_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rqfbo_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // queue state as the block should hold it
    logic [rqfbo_pkg::ITEM_W-1:0]     slot_mem [DEPTH];
    bit                               slot_written [DEPTH];
    int unsigned                      wr_ptr;
    int unsigned                      rd_ptr;
    int unsigned                      msg_cnt;
    logic [rqfbo_pkg::CFG_DATA_W-1:0] len_reg;
    logic                             count_mode;
    logic [rqfbo_pkg::CFG_DATA_W-1:0] init_reg;

    rqfbo_pkg::t_out_item expected_q [$];
    int        err_count;
    int        results_seen;
    int        reqs_sent;
    int        cycle_count;
    int        hold_left;
    bit        hold_done;

    t_plan_row dir_plan [DIR_N] = '{
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_EMPTY, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'hFFFFFFFF}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd1}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_FRONT, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd2}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0,
          '{rqfbo_pkg::REQ_OVERWRITE, 32'h12345678}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{REQ_SPARE_A, 32'hFFFFFFFF}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{REQ_SPARE_B, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{REQ_SPARE_C, 32'hA5A5A5A5}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RESET, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b1, CFG_SPARE, 5'h1F, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b1, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RESET, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'h1}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd1}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'h80000000}, 1'b1,
          '{rqfbo_pkg::ST_FULL, 32'h0, 5'd1}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_FRONT, 32'h7FFFFFFF}, 1'b1,
          '{rqfbo_pkg::ST_FULL, 32'h0, 5'd1}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0,
          '{rqfbo_pkg::REQ_OVERWRITE, 32'hDEADBEEF}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd1}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b1, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd31, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b1, rqfbo_pkg::CFG_COUNTING_ONLY, 5'd1, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b1, rqfbo_pkg::CFG_INITIAL_COUNT, 5'd31, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RESET, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd16}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'h55555555}, 1'b1,
          '{rqfbo_pkg::ST_FULL, 32'h0, 5'd16}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0,
          '{rqfbo_pkg::REQ_OVERWRITE, 32'hAAAAAAAA}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd16}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd15}},
        '{1'b1, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd4, '{rqfbo_pkg::REQ_BACK, 32'h0}, 1'b0,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd0}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_BACK, 32'h0F0F0F0F}, 1'b1,
          '{rqfbo_pkg::ST_FULL, 32'h0, 5'd15}},
        '{1'b0, rqfbo_pkg::CFG_QUEUE_LENGTH, 5'd0, '{rqfbo_pkg::REQ_RECEIVE, 32'h0}, 1'b1,
          '{rqfbo_pkg::ST_PASS, 32'h0, 5'd14}}
    };

    ring_queue_front_back_overwrite_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit quiet_stretch();
        return reqs_sent >= 700 && reqs_sent < 900;
    endfunction

    function automatic int unsigned queue_len();
        if (len_reg == 0) begin
            return 1;
        end
        if (len_reg > DEPTH) begin
            return DEPTH;
        end
        return 32'(len_reg);
    endfunction

    function automatic bit receive_hits_blank();
        int unsigned nxt;
        nxt = (rd_ptr + 1 >= queue_len()) ? 0 : rd_ptr + 1;
        return !count_mode && msg_cnt != 0 && !slot_written[nxt];
    endfunction

    function automatic rqfbo_pkg::t_out_item apply_request(rqfbo_pkg::t_in_item req);
        rqfbo_pkg::t_out_item res;
        int unsigned          len;
        len = queue_len();
        res = '{rqfbo_pkg::ST_PASS, '0, '0};
        case (req.req_type) inside
            rqfbo_pkg::REQ_BACK, rqfbo_pkg::REQ_FRONT, rqfbo_pkg::REQ_OVERWRITE: begin
                if (req.req_type != rqfbo_pkg::REQ_OVERWRITE && msg_cnt >= len) begin
                    res.status = rqfbo_pkg::ST_FULL;
                end else begin
                    if (!count_mode) begin
                        if (req.req_type == rqfbo_pkg::REQ_BACK) begin
                            slot_mem[wr_ptr]     = req.item_in;
                            slot_written[wr_ptr] = 1'b1;
                            wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
                        end else begin
                            slot_mem[rd_ptr]     = req.item_in;
                            slot_written[rd_ptr] = 1'b1;
                            rd_ptr = (rd_ptr == 0) ? len - 1 : rd_ptr - 1;
                        end
                    end
                    if (req.req_type == rqfbo_pkg::REQ_OVERWRITE && msg_cnt > 0) begin
                        msg_cnt--;
                    end
                    msg_cnt++;
                end
            end
            rqfbo_pkg::REQ_RECEIVE: begin
                if (msg_cnt == 0) begin
                    res.status = rqfbo_pkg::ST_EMPTY;
                end else begin
                    if (!count_mode) begin
                        rd_ptr = (rd_ptr + 1 >= len) ? 0 : rd_ptr + 1;
                        res.item_out = slot_mem[rd_ptr];
                    end
                    msg_cnt--;
                end
            end
            rqfbo_pkg::REQ_RESET: begin
                wr_ptr = 0;
                rd_ptr = len - 1;
                if (count_mode) begin
                    msg_cnt = (init_reg > len) ? len : 32'(init_reg);
                end else begin
                    msg_cnt = 0;
                end
            end
            default: ;
        endcase
        res.fill_count = msg_cnt[rqfbo_pkg::CNT_W-1:0];
        return res;
    endfunction

    function automatic rqfbo_pkg::t_in_item random_request(int unsigned send_pct);
        rqfbo_pkg::t_in_item req;
        int unsigned         r;
        r = $urandom_range(9);
        if (r == 0) begin
            req.item_in = '1;
        end else if (r == 1) begin
            req.item_in = '0;
        end else begin
            req.item_in = $urandom;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            req.req_type = REQ_SPARE_A + rqfbo_pkg::REQ_W'($urandom_range(2));
        end else if (r < 6) begin
            req.req_type = rqfbo_pkg::REQ_RESET;
        end else if (r < 14) begin
            req.req_type = rqfbo_pkg::REQ_OVERWRITE;
        end else if ($urandom_range(99) < send_pct) begin
            req.req_type = ($urandom_range(9) < 7) ? rqfbo_pkg::REQ_BACK : rqfbo_pkg::REQ_FRONT;
        end else begin
            req.req_type = rqfbo_pkg::REQ_RECEIVE;
        end
        // steer away from slots that hold nothing yet
        if (req.req_type == rqfbo_pkg::REQ_RECEIVE && receive_hits_blank()) begin
            req.req_type = rqfbo_pkg::REQ_BACK;
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [rqfbo_pkg::ITEM_W-1:0] got,
                                   input logic [rqfbo_pkg::ITEM_W-1:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        end
        err_count++;
    endtask

    task automatic write_reg(input logic [rqfbo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rqfbo_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            rqfbo_pkg::CFG_QUEUE_LENGTH:  len_reg    = val;
            rqfbo_pkg::CFG_COUNTING_ONLY: count_mode = val[0];
            rqfbo_pkg::CFG_INITIAL_COUNT: init_reg   = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_req(input rqfbo_pkg::t_in_item req, input bit typed,
                            input rqfbo_pkg::t_out_item want);
        rqfbo_pkg::t_out_item predicted;
        while (!quiet_stretch() && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        reqs_sent++;
        predicted = apply_request(req);
        expected_q.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) begin : check_results
        rqfbo_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_item.item_out, '0);
            end else begin
                want = expected_q.pop_front();
                if (o_out_item.status !== want.status) begin
                    report_mismatch("status", rqfbo_pkg::ITEM_W'(o_out_item.status),
                                    rqfbo_pkg::ITEM_W'(want.status));
                end
                if (o_out_item.item_out !== want.item_out) begin
                    report_mismatch("item_out", o_out_item.item_out, want.item_out);
                end
                if (o_out_item.fill_count !== want.fill_count) begin
                    report_mismatch("fill_count", rqfbo_pkg::ITEM_W'(o_out_item.fill_count),
                                    rqfbo_pkg::ITEM_W'(want.fill_count));
                end
            end
        end
        // hold off once long enough to back the queue up into the input
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_left = 150;
            hold_done = 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_stretch() || $urandom_range(99) >= 23;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_plan_row                        row;
        rqfbo_pkg::t_in_item              req;
        logic [rqfbo_pkg::CFG_DATA_W-1:0] cfg_v;
        bit                               cfg_open;
        int unsigned                      send_pct;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        for (int s = 0; s < DEPTH; s++) begin
            slot_mem[s]     = '0;
            slot_written[s] = 1'b0;
        end
        wr_ptr       = 0;
        rd_ptr       = DEPTH - 1;
        msg_cnt      = 0;
        len_reg      = 5'd16;
        count_mode   = 1'b0;
        init_reg     = 5'd0;
        err_count    = 0;
        results_seen = 0;
        reqs_sent    = 0;
        cycle_count  = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        cfg_open     = 1'b0;
        send_pct     = 50;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            row = dir_plan[k];
            if (row.is_cfg) begin
                if (!cfg_open) begin
                    settle();
                end
                write_reg(row.cfg_idx, row.cfg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                end
                cfg_open = 1'b0;
                send_req(row.req, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p < FIXED_PH) begin
                cfg_v = {4'($urandom_range(15)), PH_CNT[p]};
                write_reg(rqfbo_pkg::CFG_QUEUE_LENGTH, PH_LEN[p]);
                write_reg(rqfbo_pkg::CFG_COUNTING_ONLY, cfg_v);
                write_reg(rqfbo_pkg::CFG_INITIAL_COUNT, PH_INIT[p]);
            end else begin
                write_reg(rqfbo_pkg::CFG_QUEUE_LENGTH,
                          rqfbo_pkg::CFG_DATA_W'($urandom_range(31)));
                write_reg(rqfbo_pkg::CFG_COUNTING_ONLY,
                          rqfbo_pkg::CFG_DATA_W'($urandom_range(3) == 0));
                write_reg(rqfbo_pkg::CFG_INITIAL_COUNT,
                          rqfbo_pkg::CFG_DATA_W'($urandom_range(31)));
            end
            i_cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate fill and drain pressure
                if (n % 16 == 0) begin
                    case ($urandom_range(2))
                        0:       send_pct = 15;
                        1:       send_pct = 50;
                        default: send_pct = 85;
                    endcase
                end
                req = random_request(send_pct);
                send_req(req, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/rqfbo_pkg.sv
rtl/rqfbo_ctrl.sv
rtl/rqfbo_dp.sv
rtl/ring_queue_front_back_overwrite_top.sv
bench/ring_queue_front_back_overwrite_top_tb.sv
